FILE: rtl/base32_stream_codec_defines.svh
// Assertion macros shared by the checker of the Base32 stream codec.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BASE32_STREAM_CODEC_DEFINES_SVH
`define BASE32_STREAM_CODEC_DEFINES_SVH

// Property checked at every clock edge outside of reset.
`define B32C_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("b32c assertion failed");

// Property checked at every clock edge, reset included.
`define B32C_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("b32c assertion failed");

`endif

FILE: rtl/b32c_pkg.sv
// Package of the Base32 stream codec: beat types, result codes, register indexes.
// Depends on nothing; used by every module of the codec.
`timescale 1ns / 1ps
`default_nettype none

package b32c_pkg;

  localparam int ALPHA_WORDS = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_3 = 3'd3;

  localparam logic [63:0] ALPHA_RESET_0 = 64'd5208208757389214273;
  localparam logic [63:0] ALPHA_RESET_1 = 64'd5786930140093827657;
  localparam logic [63:0] ALPHA_RESET_2 = 64'd6365651522798441041;
  localparam logic [63:0] ALPHA_RESET_3 = 64'd3906085646303844953;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic [1:0] KIND_ENC = 2'd0;
  localparam logic [1:0] KIND_DEC = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;

  typedef logic [31:0][7:0] alphabet_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] out_kind;
    logic       last_out;
  } out_item_t;

  // One classified item: up to three results of a single kind.
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/b32c_front.sv
// Front end of the Base32 stream codec: alphabet registers, codec state, classification.
// Depends on b32c_pkg; feeds one job per accepted beat with a result into b32c_queue.
`timescale 1ns / 1ps
`default_nettype none

module b32c_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [b32c_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [b32c_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire b32c_pkg::in_item_t               in_data,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output b32c_pkg::job_t                        q_job
);

  logic [b32c_pkg::ALPHA_WORDS-1:0][63:0] alpha_r;
  b32c_pkg::alphabet_t chars;

  logic [3:0] enc_accum_r, enc_accum_nxt;
  logic [2:0] enc_count_r, enc_count_nxt;
  logic [6:0] dec_accum_r, dec_accum_nxt;
  logic [2:0] dec_count_r, dec_count_nxt;

  logic        accept;
  logic [11:0] eacc;
  logic [3:0]  ecnt0, ecnt1, ecnt2;
  logic        etwo, eflush;
  logic [4:0]  g0, g1, gp;
  logic [4:0]  emask;
  logic [3:0]  erem;
  logic [8:0]  epad;

  logic        dfound;
  logic [4:0]  didx;
  logic [11:0] dacc;
  logic [3:0]  dcnt0, dcnt1;
  logic        dbyte_ok;
  logic [7:0]  dbyte;
  logic [7:0]  dmask;

  b32c_pkg::job_t job;

  assign chars    = alpha_r;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    eacc   = {enc_accum_r, in_data.data_in};
    ecnt0  = {1'b0, enc_count_r} + 4'd8;
    g0     = 5'(eacc >> (ecnt0 - 4'd5));
    ecnt1  = ecnt0 - 4'd5;
    etwo   = ecnt1 >= 4'd5;
    g1     = 5'(eacc >> (ecnt1 - 4'd5));
    ecnt2  = etwo ? (ecnt1 - 4'd5) : ecnt1;
    emask  = (5'd1 << ecnt2) - 5'd1;
    erem   = eacc[3:0] & emask[3:0];
    epad   = {5'd0, erem} << (4'd5 - ecnt2);
    gp     = epad[4:0];
    eflush = in_data.last_in && (ecnt2 != 4'd0);
  end

  always_comb begin
    dfound = 1'b0;
    didx   = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (chars[i] == in_data.data_in) begin
        dfound = 1'b1;
        didx   = 5'(i);
      end
    end
    dacc     = {dec_accum_r, didx};
    dcnt0    = {1'b0, dec_count_r} + 4'd5;
    dbyte_ok = dcnt0 >= 4'd8;
    dbyte    = 8'(dacc >> (dcnt0 - 4'd8));
    dcnt1    = dbyte_ok ? (dcnt0 - 4'd8) : dcnt0;
    dmask    = (8'd1 << dcnt1) - 8'd1;
  end

  always_comb begin
    job           = '0;
    enc_accum_nxt = enc_accum_r;
    enc_count_nxt = enc_count_r;
    dec_accum_nxt = dec_accum_r;
    dec_count_nxt = dec_count_r;
    if (in_data.req_type == b32c_pkg::REQ_ENCODE) begin
      job.kind    = b32c_pkg::KIND_ENC;
      job.cnt     = 2'd1 + {1'b0, etwo} + {1'b0, eflush};
      job.data[0] = chars[g0];
      job.data[1] = etwo ? chars[g1] : chars[gp];
      job.data[2] = chars[gp];
      if (eflush) begin
        enc_accum_nxt = 4'd0;
        enc_count_nxt = 3'd0;
      end else begin
        enc_accum_nxt = erem;
        enc_count_nxt = ecnt2[2:0];
      end
    end else if (!dfound) begin
      job.kind = b32c_pkg::KIND_BAD;
      job.cnt  = 2'd1;
    end else begin
      job.kind      = b32c_pkg::KIND_DEC;
      job.cnt       = dbyte_ok ? 2'd1 : 2'd0;
      job.data[0]   = dbyte;
      dec_accum_nxt = dacc[6:0] & dmask[6:0];
      dec_count_nxt = dcnt1[2:0];
    end
  end

  assign q_push = accept && (job.cnt != 2'd0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r[0]  <= b32c_pkg::ALPHA_RESET_0;
      alpha_r[1]  <= b32c_pkg::ALPHA_RESET_1;
      alpha_r[2]  <= b32c_pkg::ALPHA_RESET_2;
      alpha_r[3]  <= b32c_pkg::ALPHA_RESET_3;
      enc_accum_r <= '0;
      enc_count_r <= '0;
      dec_accum_r <= '0;
      dec_count_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          b32c_pkg::REG_ALPHA_0: alpha_r[0] <= cfg_wdata;
          b32c_pkg::REG_ALPHA_1: alpha_r[1] <= cfg_wdata;
          b32c_pkg::REG_ALPHA_2: alpha_r[2] <= cfg_wdata;
          b32c_pkg::REG_ALPHA_3: alpha_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        enc_accum_r <= enc_accum_nxt;
        enc_count_r <= enc_count_nxt;
        dec_accum_r <= dec_accum_nxt;
        dec_count_r <= dec_count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b32c_queue.sv
// Two-entry job queue between the front end and the back end of the codec.
// Depends on b32c_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module b32c_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire b32c_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output b32c_pkg::job_t      head
);

  b32c_pkg::job_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic           v0_r, v0_nxt, v1_r, v1_nxt;

  assign full      = v1_r;
  assign not_empty = v0_r;
  assign head      = slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    v0_nxt    = v0_r;
    v1_nxt    = v1_r;
    if (pop) begin
      slot0_nxt = slot1_r;
      v0_nxt    = v1_r;
      v1_nxt    = 1'b0;
      if (push) begin
        if (v1_r) begin
          slot1_nxt = push_job;
          v1_nxt    = 1'b1;
        end else begin
          slot0_nxt = push_job;
          v0_nxt    = 1'b1;
        end
      end
    end else if (push) begin
      if (v0_r) begin
        slot1_nxt = push_job;
        v1_nxt    = 1'b1;
      end else begin
        slot0_nxt = push_job;
        v0_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/b32c_back.sv
// Back end: expands each queued job into result beats, one per cycle while not stalled.
// Depends on b32c_pkg; drives the registered result channel.
`timescale 1ns / 1ps
`default_nettype none

module b32c_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire b32c_pkg::job_t job_in,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output b32c_pkg::out_item_t out_data
);

  b32c_pkg::job_t      job_r, job_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  b32c_pkg::out_item_t out_data_r, out_data_nxt;
  logic                load_ok;
  logic                last_item;

  assign load_ok   = !out_valid_r || !out_stall;
  assign last_item = idx_r == (job_r.cnt - 2'd1);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (load_ok) begin
      if (busy_r) begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.data_out = job_r.data[idx_r];
        out_data_nxt.out_kind = job_r.kind;
        out_data_nxt.last_out = last_item;
        if (last_item) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end else if (job_valid) begin
        pop                   = 1'b1;
        out_valid_nxt         = 1'b1;
        out_data_nxt.data_out = job_in.data[0];
        out_data_nxt.out_kind = job_in.kind;
        out_data_nxt.last_out = job_in.cnt == 2'd1;
        if (job_in.cnt != 2'd1) begin
          busy_nxt = 1'b1;
          job_nxt  = job_in;
          idx_nxt  = 2'd1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/base32_stream_codec.sv
// Top level of the unpadded Base32 stream codec; joins front end, job queue and back end.
// Depends on b32c_pkg, b32c_front, b32c_queue and b32c_back.
// Each job passes through the job queue register, then the output register of the back end.
// Throughput: one result beat per cycle while out_stall is low; an item yields one to
// three result beats, one per result; a decode beat with no result yields no output beat.
// Reset is synchronous and active low; it clears codec state and loads the default alphabet.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_codec (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [b32c_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [b32c_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire b32c_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output b32c_pkg::out_item_t                   out_data
);

  logic           q_push, q_full, q_pop, q_not_empty;
  b32c_pkg::job_t q_job, q_head;

  b32c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  b32c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b32c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job_in    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/b32c_checker.sv
// Port-level checker of the Base32 stream codec, bound to the top level.
// Depends on b32c_pkg and base32_stream_codec_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "base32_stream_codec_defines.svh"

module b32c_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire b32c_pkg::out_item_t out_data
);

  `B32C_ASSERT(a_stalled_beat_holds, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_data)))
  `B32C_ASSERT(a_bad_char_beat, clk, rst_n, (out_valid && out_data.out_kind == b32c_pkg::KIND_BAD |-> out_data.data_out == 8'd0 && out_data.last_out))
  `B32C_ASSERT(a_decoded_byte_is_last, clk, rst_n, (out_valid && out_data.out_kind == b32c_pkg::KIND_DEC |-> out_data.last_out))
  `B32C_ASSERT_ALWAYS(a_reset_clears_output, clk, (!rst_n |=> !out_valid))

endmodule

bind base32_stream_codec b32c_checker u_b32c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for base32_stream_codec: directed and random encode and decode beats
// under random idling and back-pressure, checked against a predictor of the codec.
// Depends on b32c_pkg and the codec RTL.
`timescale 1ns / 1ps

module tb;

  typedef logic [b32c_pkg::ALPHA_WORDS-1:0][b32c_pkg::CFG_DATA_W-1:0] alpha_words_t;

  localparam int IDLE_PCT        = 33;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 3000;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [b32c_pkg::CFG_INDEX_W-1:0] ALPHA_REGS [b32c_pkg::ALPHA_WORDS] =
    '{b32c_pkg::REG_ALPHA_0, b32c_pkg::REG_ALPHA_1, b32c_pkg::REG_ALPHA_2,
      b32c_pkg::REG_ALPHA_3};
  localparam logic [b32c_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST = b32c_pkg::REG_ALPHA_3 + 1'b1;
  localparam logic [b32c_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;
  localparam alpha_words_t RESET_WORDS = {b32c_pkg::ALPHA_RESET_3, b32c_pkg::ALPHA_RESET_2,
                                          b32c_pkg::ALPHA_RESET_1, b32c_pkg::ALPHA_RESET_0};

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [b32c_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [b32c_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  b32c_pkg::in_item_t               in_data;
  logic                             out_valid;
  logic                             out_stall;
  b32c_pkg::out_item_t              out_data;

  b32c_pkg::alphabet_t alpha_tbl;
  logic [11:0]         enc_bits;
  int                  enc_held;
  logic [11:0]         dec_bits;
  int                  dec_held;

  b32c_pkg::out_item_t pending_codec_beats[$];
  int                  mismatch_count;
  int                  quiet_cycles;
  bit                  gaps_on;
  bit                  hold_off_req;

  base32_stream_codec u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_codec_beat(logic [7:0] data, logic [1:0] kind);
    b32c_pkg::out_item_t beat;
    beat.data_out = data;
    beat.out_kind = kind;
    beat.last_out = 1'b0;
    pending_codec_beats.push_back(beat);
  endfunction

  function automatic void predict_codec_beats(b32c_pkg::in_item_t item);
    logic [11:0] acc;
    logic [11:0] group;
    int          cnt;
    int          produced;
    int          idx;
    bit          found;
    produced = 0;
    if (item.req_type == b32c_pkg::REQ_ENCODE) begin
      cnt = enc_held + 8;
      acc = {enc_bits[3:0], item.data_in};
      while (cnt >= 5) begin
        cnt -= 5;
        group = acc >> cnt;
        push_codec_beat(alpha_tbl[group[4:0]], b32c_pkg::KIND_ENC);
        produced++;
      end
      acc &= (12'd1 << cnt) - 12'd1;
      if (item.last_in && cnt > 0) begin
        group = acc << (5 - cnt);
        push_codec_beat(alpha_tbl[group[4:0]], b32c_pkg::KIND_ENC);
        produced++;
        acc = '0;
        cnt = 0;
      end
      enc_bits = acc;
      enc_held = cnt;
    end else begin
      found = 1'b0;
      idx = 0;
      for (int i = 0; i < 32; i++) begin
        if (!found && alpha_tbl[i] == item.data_in) begin
          found = 1'b1;
          idx = i;
        end
      end
      if (!found) begin
        push_codec_beat(8'h00, b32c_pkg::KIND_BAD);
        produced++;
      end else begin
        cnt = dec_held + 5;
        acc = {dec_bits[6:0], idx[4:0]};
        if (cnt >= 8) begin
          cnt -= 8;
          group = acc >> cnt;
          push_codec_beat(group[7:0], b32c_pkg::KIND_DEC);
          produced++;
        end
        dec_bits = acc & ((12'd1 << cnt) - 12'd1);
        dec_held = cnt;
      end
    end
    if (produced > 0) pending_codec_beats[$].last_out = 1'b1;
  endfunction

  function automatic b32c_pkg::in_item_t codec_item(logic req, logic [7:0] data, logic last);
    b32c_pkg::in_item_t item;
    item.req_type = req;
    item.data_in  = data;
    item.last_in  = last;
    return item;
  endfunction

  function automatic b32c_pkg::in_item_t random_codec_item();
    b32c_pkg::in_item_t item;
    item.req_type = $urandom_range(0, 1) ? b32c_pkg::REQ_DECODE : b32c_pkg::REQ_ENCODE;
    item.last_in  = ($urandom_range(0, 4) == 0);
    if (item.req_type == b32c_pkg::REQ_DECODE && $urandom_range(0, 9) < 8) begin
      item.data_in = alpha_tbl[5'($urandom_range(0, 31))];
    end else begin
      item.data_in = 8'($urandom_range(0, 255));
    end
    return item;
  endfunction

  function automatic void report_mismatch(string what, b32c_pkg::out_item_t want,
                                          b32c_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected data %h kind %0d last %0d, got data %h kind %0d last %0d",
               $realtime, what, want.data_out, want.out_kind, want.last_out,
               got.data_out, got.out_kind, got.last_out);
    end
  endfunction

  always @(posedge clk) begin
    b32c_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codec_beats.size() == 0) begin
        report_mismatch("unexpected result beat", '0, out_data);
      end else begin
        want = pending_codec_beats.pop_front();
        if (out_data.data_out !== want.data_out || out_data.out_kind !== want.out_kind ||
            out_data.last_out !== want.last_out) begin
          report_mismatch("result beat mismatch", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(b32c_pkg::in_item_t item);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_codec_beats(item);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_codec_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Every load also writes one unused register index, which must leave the alphabet alone.
  task automatic load_alphabet(alpha_words_t words);
    int spare;
    wait_drained();
    for (int w = 0; w <= b32c_pkg::ALPHA_WORDS; w++) begin
      cfg_we <= 1'b1;
      if (w < b32c_pkg::ALPHA_WORDS) begin
        cfg_index <= ALPHA_REGS[w];
        cfg_wdata <= words[w];
        for (int b = 0; b < 8; b++) alpha_tbl[w * 8 + b] = words[w][b * 8 +: 8];
      end else begin
        spare = $urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST);
        cfg_index <= spare[b32c_pkg::CFG_INDEX_W-1:0];
        cfg_wdata <= {$urandom, $urandom};
      end
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_encode_directed();
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h00, 1'b1));
    for (int i = 0; i < 5; i++) send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'hFF, i == 4));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'hA5, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h5A, 1'b1));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h3C, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h96, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'hE1, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h0F, 1'b1));
  endtask

  task automatic test_decode_directed();
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[0], 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[31], 1'b1));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h00, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'hFF, 1'b1));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h61, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[16], 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[1], 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[30], 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[7], 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[8], 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[24], 1'b1));
    send_item(codec_item(b32c_pkg::REQ_DECODE, alpha_tbl[15], 1'b0));
  endtask

  task automatic test_alphabet_registers();
    alpha_words_t words;
    load_alphabet('0);
    for (int i = 0; i < 6; i++) send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h00, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h41, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'hFF, 1'b1));
    load_alphabet('1);
    for (int i = 0; i < 4; i++) send_item(codec_item(b32c_pkg::REQ_DECODE, 8'hFF, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h00, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h81, 1'b1));
    for (int w = 0; w < b32c_pkg::ALPHA_WORDS; w++) begin
      for (int b = 0; b < 8; b++) words[w][b * 8 +: 8] = $urandom_range(0, 2) ? 8'h42 : 8'h00;
    end
    load_alphabet(words);
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h42, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h00, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_DECODE, 8'h43, 1'b0));
    send_item(codec_item(b32c_pkg::REQ_ENCODE, 8'h7E, 1'b1));
  endtask

  task automatic test_backpressure();
    load_alphabet(RESET_WORDS);
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(random_codec_item());
    wait_drained();
    for (int i = 0; i < 20; i++) send_item(random_codec_item());
  endtask

  task automatic test_random_traffic();
    alpha_words_t words;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: for (int w = 0; w < b32c_pkg::ALPHA_WORDS; w++) words[w] = {$urandom, $urandom};
        1: words = RESET_WORDS;
        2: begin
          for (int w = 0; w < b32c_pkg::ALPHA_WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
              words[w][b * 8 +: 8] = $urandom_range(0, 3) ? 8'($urandom_range(0, 255)) : 8'h00;
            end
          end
        end
        default: begin
          for (int w = 0; w < b32c_pkg::ALPHA_WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
              words[w][b * 8 +: 8] = 8'($urandom_range(8'h41, 8'h44));
            end
          end
        end
      endcase
      load_alphabet(words);
      gaps_on = (phase != 1);
      for (int i = 0; i < 80; i++) send_item(random_codec_item());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    gaps_on        = 1'b1;
    hold_off_req   = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    alpha_tbl      = RESET_WORDS;
    enc_bits       = '0;
    enc_held       = 0;
    dec_bits       = '0;
    dec_held       = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_encode_directed();
    test_decode_directed();
    test_alphabet_registers();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
